### design/integer_to_ascii_formatter_assert.svh
// Assertion macros for the formatter RTL.
// Used by i2a_seq.sv; no other dependencies.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define I2A_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("i2a assertion failed");

// Next-cycle implication, disabled in reset.
`define I2A_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("i2a assertion failed");

`endif

### design/i2a_pkg.sv
// Types, constants and helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int NDIG     = 10;            // BCD digits held in the digit register
  localparam int HEX_NDIG = 8;
  localparam int WORD_W   = 32;
  localparam int DIG_W    = 4 * NDIG;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_X     = 8'h78;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DEC,
    OP_LOAD_HEX,
    OP_STEP,
    OP_SHIFT
  } op_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CHAR_0 + {4'h0, n};
    end else begin
      r = CHAR_A + {4'h0, n} - 8'd10;
    end
    return r;
  endfunction

endpackage

### design/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
// Depends on i2a_pkg, i2a_conv and i2a_seq.
//
//  channel  ports                       handshake
//  input    cmd (in_t: func, value)     start, taken when busy is low
//  output   result (out_t: ch, last)    strobe, one per character
//
// Decimal: a load, the shift/add-3 steps over every magnitude bit, '-' if
// negative, then leading zero digits are dropped one at a time (at least one
// digit is kept) and the remaining digits are emitted. Hex: a load, the '0'
// and 'x' prefix characters, then the same zero skip and digit emission. Each
// character strobes in the cycle after its emit cycle, so the last one overlaps
// the idle cycle that can take the next word. Reset is synchronous and clears
// only control state. The receiver cannot stall; results stream out.
`timescale 1ns / 1ps

module integer_to_ascii_formatter import i2a_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  in_t  cmd,
  output logic busy,
  output logic strobe,
  output out_t result
);

  op_t        op;
  logic [3:0] top;

  i2a_conv u_conv (
    .clk   (clk),
    .op    (op),
    .value (cmd.value),
    .top   (top)
  );

  i2a_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .top    (top),
    .op     (op),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

endmodule

### design/i2a_conv.sv
// Digit register with the shift/add-3 unit (binary to BCD, one bit
// per cycle) and a one-digit left shift for emission. Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_conv import i2a_pkg::*; (
  input  logic              clk,
  input  op_t               op,
  input  logic [WORD_W-1:0] value,
  output logic [3:0]        top
);

  logic [WORD_W-1:0] mag;
  logic [DIG_W-1:0]  dig;
  logic [DIG_W-1:0]  adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD_DEC: begin
        mag <= value[WORD_W-1] ? (~value + 1'b1) : value;
        dig <= '0;
      end
      OP_LOAD_HEX: begin
        mag <= '0;
        dig <= {value, {(DIG_W-WORD_W){1'b0}}};
      end
      OP_STEP: begin
        dig <= {adj[DIG_W-2:0], mag[WORD_W-1]};
        mag <= {mag[WORD_W-2:0], 1'b0};
      end
      OP_SHIFT: begin
        dig <= {dig[DIG_W-5:0], 4'h0};
      end
      default: begin
      end
    endcase
  end

  assign top = dig[DIG_W-1 -: 4];

endmodule

### design/i2a_seq.sv
// Sequencer: drives the digit unit, emits sign/prefix/digit characters.
// Depends on i2a_pkg and integer_to_ascii_formatter_assert.svh.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_assert.svh"

module i2a_seq import i2a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  in_t        cmd,
  input  logic [3:0] top,
  output op_t        op,
  output logic       busy,
  output logic       strobe,
  output out_t       result
);

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [3:0] rem, rem_next;
  logic       neg, neg_next;
  logic       emit;
  out_t       emit_word;

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rem_next   = rem;
    neg_next   = neg;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cnt_next   = '0;
          neg_next   = ~cmd.func & cmd.value[WORD_W-1];
          rem_next   = cmd.func ? 4'(HEX_NDIG) : 4'(NDIG);
          state_next = cmd.func ? ST_PFX0 : ST_CONV;
        end
      end
      ST_CONV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(WORD_W-1)) begin
          state_next = neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: state_next = ST_SKIP;
      ST_PFX0: state_next = ST_PFXX;
      ST_PFXX: state_next = ST_SKIP;
      ST_SKIP: begin
        if (top == 4'h0 && rem > 4'd1) begin
          rem_next = rem - 4'd1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rem_next = rem - 4'd1;
        if (rem == 4'd1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op             = OP_HOLD;
    emit           = 1'b0;
    emit_word.ch   = hex_char(top);
    emit_word.last = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          op = cmd.func ? OP_LOAD_HEX : OP_LOAD_DEC;
        end
      end
      ST_CONV: op = OP_STEP;
      ST_SIGN: begin
        emit         = 1'b1;
        emit_word.ch = CHAR_MINUS;
      end
      ST_PFX0: begin
        emit         = 1'b1;
        emit_word.ch = CHAR_0;
      end
      ST_PFXX: begin
        emit         = 1'b1;
        emit_word.ch = CHAR_X;
      end
      ST_SKIP: begin
        if (top == 4'h0 && rem > 4'd1) begin
          op = OP_SHIFT;
        end
      end
      ST_EMIT: begin
        op             = OP_SHIFT;
        emit           = 1'b1;
        emit_word.last = (rem == 4'd1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
      cnt    <= '0;
      rem    <= '0;
      neg    <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      cnt    <= cnt_next;
      rem    <= rem_next;
      neg    <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_word;
    end
  end

  assign busy = (state != ST_IDLE);

  `I2A_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `I2A_ASSERT_NXT(a_gap_after_last, clk, rst, strobe && result.last, !strobe)
  `I2A_ASSERT_IMP(a_idle_strobe_last, clk, rst, strobe && !busy, result.last)
  `I2A_ASSERT_IMP(a_emit_rem, clk, rst, state == ST_EMIT, rem != 4'd0)

endmodule
